// ----- rtl/pbtma_pkg.sv -----
// Shared constants, types and state codes of the per-beam temporal moving average.
// No dependencies; every other file of the block imports this package.
package pbtma_pkg;

	localparam int MAX_BEAMS  = 2048;
	localparam int MAX_WINDOW = 8;
	localparam int RANGE_BITS = 16;

	localparam int BEAM_W   = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
	localparam int SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
	localparam int COUNT_W  = $clog2(MAX_BEAMS + 1);
	localparam int ENTRY_W  = RANGE_BITS + 1;
	localparam int SUM_W    = RANGE_BITS + $clog2(MAX_WINDOW) + 1;
	localparam int SHIFT    = SUM_W + $clog2(MAX_WINDOW) + 1;
	localparam int RECIP_W  = SHIFT + 1;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam int DATA_W   = ((RANGE_BITS + 7) / 8) * 8;

	localparam int CFG_WIN_W   = 4;
	localparam int CFG_BEAMS_W = 12;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [CFG_WIN_W-1:0]   WINDOW_LEN_RESET = 4'd4;
	localparam logic [CFG_BEAMS_W-1:0] BEAM_COUNT_RESET = 12'd1080;

	localparam logic REG_WINDOW_LEN = 1'b0;
	localparam logic REG_BEAM_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [RANGE_BITS-1:0] range_mm;
		logic                  range_ok;
		logic [SLOT_W-1:0]     slot;
		logic [CNT_W-1:0]      n;
		logic                  overflow;
		logic                  last;
	} item_t;

	typedef struct packed {
		logic sum_en;
		logic mul_en;
	} stage_en_t;

	typedef struct packed {
		logic [RANGE_BITS-1:0] average_mm;
		logic                  average_ok;
		logic                  end_of_scan;
	} result_t;

endpackage

// ----- rtl/pbtma_history.sv -----
// Banked history store: one synchronous bank per scan slot, all read at one beam address.
// Depends on pbtma_pkg.
module pbtma_history
	import pbtma_pkg::*;
(
	input  logic               clk,
	input  logic               access,
	input  logic [BEAM_W-1:0]  addr,
	input  logic [SLOT_W-1:0]  wr_slot,
	input  logic [ENTRY_W-1:0] wr_data,
	output logic [ENTRY_W-1:0] rd_data [MAX_WINDOW]
);

	for (genvar b = 0; b < MAX_WINDOW; b++) begin : g_bank
		logic [ENTRY_W-1:0] mem [MAX_BEAMS];

		always_ff @(posedge clk) begin
			if (access && wr_slot == SLOT_W'(b)) begin
				mem[addr] <= wr_data;
			end
			if (access) begin
				rd_data[b] <= mem[addr];
			end
		end
	end

endmodule

// ----- rtl/pbtma_avg.sv -----
// Window sum, rounding and division by reciprocal multiplication over two stages.
// Depends on pbtma_pkg.
module pbtma_avg
	import pbtma_pkg::*;
(
	input  logic               clk,
	input  stage_en_t          en,
	input  item_t              item,
	input  logic [ENTRY_W-1:0] rd_data [MAX_WINDOW],
	output result_t            result
);

	logic [RECIP_W-1:0] recip [MAX_WINDOW + 1];
	logic [SUM_W-1:0]   sum_c;
	logic               ok_c;
	logic [SLOT_W:0]    age;
	logic [ENTRY_W-1:0] entry;

	logic [SUM_W-1:0]   sum_s2;
	logic [CNT_W-1:0]   n_s2;
	logic               ok_s2;
	logic               last_s2;
	logic [PROD_W-1:0]  prod_s3;
	logic               ok_s3;
	logic               last_s3;

	assign recip[0] = '0;
	for (genvar D = 1; D <= MAX_WINDOW; D++) begin : g_recip
		assign recip[D] = RECIP_W'(((2 ** SHIFT) + D - 1) / D);
	end

	always_comb begin
		sum_c = '0;
		ok_c  = 1'b1;
		age   = '0;
		entry = '0;
		for (int b = 0; b < MAX_WINDOW; b++) begin
			if (item.slot >= SLOT_W'(b)) begin
				age = (SLOT_W + 1)'(item.slot) - (SLOT_W + 1)'(b);
			end else begin
				age = (SLOT_W + 1)'(item.slot) + (SLOT_W + 1)'(MAX_WINDOW - b);
			end
			entry = (item.slot == SLOT_W'(b)) ? {item.range_ok, item.range_mm} : rd_data[b];
			if (age < item.n) begin
				sum_c = sum_c + SUM_W'(entry[RANGE_BITS-1:0]);
				ok_c  = ok_c & entry[RANGE_BITS];
			end
		end
		ok_c = ok_c & ~item.overflow;
	end

	always_ff @(posedge clk) begin
		if (en.sum_en) begin
			sum_s2  <= sum_c + SUM_W'(item.n >> 1);
			n_s2    <= item.n;
			ok_s2   <= ok_c;
			last_s2 <= item.last;
		end
		if (en.mul_en) begin
			prod_s3 <= PROD_W'(sum_s2) * PROD_W'(recip[n_s2]);
			ok_s3   <= ok_s2;
			last_s3 <= last_s2;
		end
	end

	assign result.average_mm  = ok_s3 ? prod_s3[SHIFT +: RANGE_BITS] : '0;
	assign result.average_ok  = ok_s3;
	assign result.end_of_scan = last_s3;

endmodule

// ----- rtl/per_beam_temporal_moving_average_core.sv -----
// Top level of the per-beam temporal moving average: control, counters, registers, output.
// Depends on pbtma_pkg, pbtma_history and pbtma_avg.
//
// Range readings enter one beat per beam on the s_ channel; tdata carries range_mm and
// tuser carries range_ok. Each beat yields one result beat on the m_ channel: tdata is
// the rounded mean of the newest window_len readings of that beam, tuser is average_ok
// and tlast marks the final beam of a scan. The APB port holds window_len at address 0
// and beam_count at address 4; the user must write it only while the block is idle, as
// the block itself does not enforce this. An accepted beat goes through the history
// read, the window sum, the reciprocal multiply and the output register in order; the
// block takes one beam at a time and takes no new beat until its result is in the output
// register. Each scan slot is its own bank, so a single memory access returns the whole
// history of a beam. Reset clears the counters and the registers to their defaults at
// once; the history memory is not cleared and needs no sweep. When the receiver stalls,
// the result waits in the output register; one more beat is still taken and waits at the
// end of the pipeline, and further beats are held off until the output register is free.
module per_beam_temporal_moving_average_core
	import pbtma_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DATA_W-1:0]     s_tdata,   // range_mm
	input  logic                  s_tuser,   // range_ok
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_W-1:0]     m_tdata,   // average_mm
	output logic                  m_tuser,   // average_ok
	output logic                  m_tlast,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	state_t state_q, state_d;

	logic [CFG_WIN_W-1:0]   window_len_q;
	logic [CFG_BEAMS_W-1:0] beam_count_q;
	logic [CNT_W-1:0]       scans_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [BEAM_W-1:0]      beam_q;
	logic                   m_valid_q;
	result_t                out_q;
	item_t                  item_s1;

	logic                   accept;
	logic                   cfg_write;
	logic                   out_load;
	stage_en_t              en;
	logic [CNT_W-1:0]       win_eff;
	logic [COUNT_W-1:0]     count_eff;
	logic                   overflow;
	logic [CNT_W-1:0]       n_c;
	logic [BEAM_W:0]        beam_next;
	logic                   last_c;
	logic [ENTRY_W-1:0]     rd_data [MAX_WINDOW];
	result_t                result;

	assign accept    = s_tvalid & s_tready;
	assign cfg_write = psel & penable & pwrite & pready;
	assign pready    = 1'b1;

	always_comb begin
		if (window_len_q == '0) begin
			win_eff = CNT_W'(1);
		end else if (window_len_q > MAX_WINDOW) begin
			win_eff = CNT_W'(MAX_WINDOW);
		end else begin
			win_eff = CNT_W'(window_len_q);
		end
		overflow = beam_count_q > MAX_BEAMS;
		if (beam_count_q == '0) begin
			count_eff = COUNT_W'(1);
		end else if (overflow) begin
			count_eff = COUNT_W'(MAX_BEAMS);
		end else begin
			count_eff = COUNT_W'(beam_count_q);
		end
		n_c       = (scans_q >= win_eff) ? win_eff : scans_q + CNT_W'(1);
		beam_next = {1'b0, beam_q} + (BEAM_W + 1)'(1);
		last_c    = beam_next >= count_eff;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_SUM;
			ST_SUM:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_OUT;
			ST_OUT:  if (!m_valid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = state_q == ST_IDLE;
		en.sum_en = state_q == ST_SUM;
		en.mul_en = state_q == ST_MUL;
		out_load  = (state_q == ST_OUT) && (!m_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			window_len_q <= WINDOW_LEN_RESET;
			beam_count_q <= BEAM_COUNT_RESET;
			scans_q      <= '0;
			slot_q       <= '0;
			beam_q       <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (paddr[2])
					REG_WINDOW_LEN: window_len_q <= pwdata[CFG_WIN_W-1:0];
					REG_BEAM_COUNT: beam_count_q <= pwdata[CFG_BEAMS_W-1:0];
					default:        ;
				endcase
			end
			if (accept) begin
				if (last_c) begin
					beam_q <= '0;
					slot_q <= (slot_q == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
					if (scans_q < MAX_WINDOW) begin
						scans_q <= scans_q + CNT_W'(1);
					end
				end else begin
					beam_q <= beam_next[BEAM_W-1:0];
				end
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.range_mm <= s_tdata[RANGE_BITS-1:0];
			item_s1.range_ok <= s_tuser;
			item_s1.slot     <= slot_q;
			item_s1.n        <= n_c;
			item_s1.overflow <= overflow;
			item_s1.last     <= last_c;
		end
		if (out_load) begin
			out_q <= result;
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW_LEN: prdata = APB_DATA_W'(window_len_q);
			REG_BEAM_COUNT: prdata = APB_DATA_W'(beam_count_q);
			default:        prdata = '0;
		endcase
	end

	pbtma_history u_history (
		.clk     (clk),
		.access  (accept),
		.addr    (beam_q),
		.wr_slot (slot_q),
		.wr_data ({s_tuser, s_tdata[RANGE_BITS-1:0]}),
		.rd_data (rd_data)
	);

	pbtma_avg u_avg (
		.clk     (clk),
		.en      (en),
		.item    (item_s1),
		.rd_data (rd_data),
		.result  (result)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = DATA_W'(out_q.average_mm);
	assign m_tuser  = out_q.average_ok;
	assign m_tlast  = out_q.end_of_scan;

	a_accept_starts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SUM)
		else $error("accepted beat did not start the window sum");

	a_last_wraps_beam: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_c |=> beam_q == '0)
		else $error("beam position did not wrap at end of scan");

	a_scans_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		scans_q <= MAX_WINDOW)
		else $error("completed scan count beyond window depth");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("invalid result carries a nonzero average");

endmodule

// ----- tb/sv/tb_per_beam_temporal_moving_average_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of per_beam_temporal_moving_average_core: range beats go in on the
// slave stream and every result beat is checked in order against a per-beam window predictor.
// Depends on pbtma_pkg and the block's RTL; window_len and beam_count are set over APB.
module tb_per_beam_temporal_moving_average_core;
	import pbtma_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RANDOM_BEATS = 1700;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 4000;
	localparam int HIST_DEPTH   = MAX_BEAMS * MAX_WINDOW;

	class beam_average_scoreboard;
		bit [ENTRY_W-1:0]       history [HIST_DEPTH];
		bit                     written [HIST_DEPTH];
		int unsigned            scans_seen;
		int unsigned            slot_ptr;
		int unsigned            beam_pos;
		logic [CFG_WIN_W-1:0]   window_reg;
		logic [CFG_BEAMS_W-1:0] count_reg;
		result_t                expected_q [$];
		int                     errors;

		function new();
			scans_seen = 0;
			slot_ptr   = 0;
			beam_pos   = 0;
			window_reg = WINDOW_LEN_RESET;
			count_reg  = BEAM_COUNT_RESET;
			errors     = 0;
		endfunction

		static function int unsigned eff_window(logic [CFG_WIN_W-1:0] w);
			if (w == 0)
				return 1;
			if (w > MAX_WINDOW)
				return MAX_WINDOW;
			return w;
		endfunction

		static function int unsigned eff_count(logic [CFG_BEAMS_W-1:0] c);
			if (c == 0)
				return 1;
			if (c > MAX_BEAMS)
				return MAX_BEAMS;
			return c;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// True when the coming scans, started at beam zero, read only history already written.
		function bit history_covers(int unsigned win, int unsigned cnt);
			int unsigned j, k, n, ss, s, b;
			for (j = 0; j < win; j++) begin
				ss = (scans_seen + j > MAX_WINDOW) ? MAX_WINDOW : scans_seen + j;
				n = (ss + 1 > win) ? win : ss + 1;
				for (k = j + 1; k < n; k++) begin
					s = (slot_ptr + 2 * MAX_WINDOW + j - k) % MAX_WINDOW;
					for (b = 0; b < cnt; b++)
						if (!written[s * MAX_BEAMS + b])
							return 0;
				end
			end
			return 1;
		endfunction

		function void note_input(logic [RANGE_BITS-1:0] range_mm, logic range_ok);
			int unsigned win, cnt, n, k, beam, slot, idx, sum, avg;
			bit overflow, all_ok, last;
			bit [ENTRY_W-1:0] e;
			result_t res;
			win = eff_window(window_reg);
			cnt = eff_count(count_reg);
			overflow = (count_reg > MAX_BEAMS);
			beam = beam_pos % MAX_BEAMS;
			slot = slot_ptr % MAX_WINDOW;
			idx = slot * MAX_BEAMS + beam;
			history[idx] = {range_ok, range_mm};
			written[idx] = 1'b1;
			n = (scans_seen + 1 > win) ? win : scans_seen + 1;
			sum = 0;
			all_ok = 1'b1;
			for (k = 0; k < n; k++) begin
				e = history[((slot + MAX_WINDOW - k) % MAX_WINDOW) * MAX_BEAMS + beam];
				if (!e[RANGE_BITS])
					all_ok = 1'b0;
				sum += e[RANGE_BITS-1:0];
			end
			if (overflow)
				all_ok = 1'b0;
			avg = all_ok ? (sum + n / 2) / n : 0;
			last = (beam + 1 >= cnt);
			if (last) begin
				beam_pos = 0;
				slot_ptr = (slot + 1) % MAX_WINDOW;
				if (scans_seen < MAX_WINDOW)
					scans_seen++;
			end else begin
				beam_pos = (beam + 1) % MAX_BEAMS;
			end
			res.average_mm  = avg[RANGE_BITS-1:0];
			res.average_ok  = all_ok;
			res.end_of_scan = last;
			expected_q.insert(expected_q.size(), res);
		endfunction

		function void check_result(logic [DATA_W-1:0] tdata, logic tuser, logic tlast);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("result beat with no expectation waiting: average_mm=%0d average_ok=%0b",
					tdata, tuser);
				errors++;
				return;
			end
			want = expected_q[0];
			expected_q.delete(0);
			if (tdata !== DATA_W'(want.average_mm)) begin
				$error("average_mm mismatch: expected %0d, got %0d", want.average_mm, tdata);
				errors++;
			end
			if (tuser !== want.average_ok) begin
				$error("average_ok mismatch: expected %0b, got %0b", want.average_ok, tuser);
				errors++;
			end
			if (tlast !== want.end_of_scan) begin
				$error("end_of_scan mismatch: expected %0b, got %0b", want.end_of_scan, tlast);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata;   // range_mm
	logic                  s_tuser;   // range_ok
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DATA_W-1:0]     m_tdata;   // average_mm
	logic                  m_tuser;   // average_ok
	logic                  m_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	beam_average_scoreboard sb = new();
	int beats_sent   = 0;
	bit steady       = 1'b0;
	bit hold_request = 1'b0;

	per_beam_temporal_moving_average_core dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ENTRY_W-1:0] random_reading();
		logic [RANGE_BITS-1:0] r;
		logic ok;
		case ($urandom_range(0, 7))
			0: r = '0;
			1: r = '1;
			2: r = {RANGE_BITS{1'b1}} - RANGE_BITS'($urandom_range(0, 255));
			default: r = RANGE_BITS'($urandom);
		endcase
		ok = ($urandom_range(0, 24) != 0);
		return {ok, r};
	endfunction

	task automatic send_beat(input logic [RANGE_BITS-1:0] range_mm, input logic range_ok);
		int gap;
		gap = steady ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= DATA_W'(range_mm);
		s_tuser  <= range_ok;
		do @(posedge clk); while (!s_tready);
		sb.note_input(range_mm, range_ok);
		beats_sent++;
	endtask

	task automatic send_random_beats(input int unsigned count);
		logic [ENTRY_W-1:0] e;
		repeat (count) begin
			e = random_reading();
			send_beat(e[RANGE_BITS-1:0], e[RANGE_BITS]);
		end
	endtask

	// Drops the input stream and waits until every expected result beat has come out.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write_reg(input logic reg_index, input logic [APB_DATA_W-1:0] value,
		input logic [APB_DATA_W-1:0] mask, input string name);
		logic [APB_ADDR_W-1:0] addr;
		addr = APB_ADDR_W'(4 * reg_index);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== (value & mask)) begin
			$error("%s readback mismatch: expected %0d, got %0d", name, value & mask, prdata);
			sb.errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_regs(input logic [CFG_WIN_W-1:0] w, input logic [CFG_BEAMS_W-1:0] c);
		logic [APB_DATA_W-1:0] noise;
		drain();
		noise = $urandom;
		apb_write_reg(REG_WINDOW_LEN, {noise[APB_DATA_W-1:CFG_WIN_W], w},
			APB_DATA_W'((1 << CFG_WIN_W) - 1), "window_len");
		sb.window_reg = w;
		noise = $urandom;
		apb_write_reg(REG_BEAM_COUNT, {noise[APB_DATA_W-1:CFG_BEAMS_W], c},
			APB_DATA_W'((1 << CFG_BEAMS_W) - 1), "beam_count");
		sb.count_reg = c;
	endtask

	// A window wider than one may only start at beam zero on history that is fully written.
	task automatic configure(input logic [CFG_WIN_W-1:0] w, input logic [CFG_BEAMS_W-1:0] c);
		int unsigned win, cnt;
		win = beam_average_scoreboard::eff_window(w);
		cnt = beam_average_scoreboard::eff_count(c);
		if (win > 1 && (sb.beam_pos != 0 || !sb.history_covers(win, cnt))) begin
			// A window of one reads only the beat just written, so it can refill any history.
			program_regs(4'd1, c);
			while (sb.beam_pos != 0)
				send_random_beats(1);
			while (!sb.history_covers(win, cnt))
				send_random_beats(cnt);
		end
		program_regs(w, c);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
	end

	initial begin : ready_driver
		int low_left;
		low_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				low_left = HOLD_CYCLES;
			end
			if (low_left > 0) begin
				m_tready <= 1'b0;
				low_left--;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					low_left = pick_gap();
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int unsigned i, start_beats, nscans, beats, cnt_eff;
		int win_sel, cnt_sel;
		logic [CFG_WIN_W-1:0] w;
		logic [CFG_BEAMS_W-1:0] c;
		bit stall_done;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		stall_done = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings first, on an empty history.
		send_beat('0, 1'b1);
		send_beat('1, 1'b1);
		send_beat(16'd12345, 1'b0);
		// The beam count drops below the current position, so the next beat ends the scan.
		configure(CFG_WIN_W'(MAX_WINDOW), 12'd2);
		// The window grows scan by scan; beam zero holds the largest sum throughout.
		for (i = 0; i < MAX_WINDOW; i++) begin
			send_beat('1, 1'b1);
			send_beat(RANGE_BITS'(i * 9001), i != 5);
		end

		start_beats = beats_sent;
		configure(4'd1, CFG_BEAMS_W'(MAX_BEAMS));
		send_random_beats($urandom_range(40, 120));
		configure(4'd0, CFG_BEAMS_W'($urandom_range(MAX_BEAMS + 1, 4095)));
		send_random_beats($urandom_range(20, 60));
		while (beats_sent - start_beats < RANDOM_BEATS) begin
			win_sel = $urandom_range(0, 9);
			case (win_sel)
				0: w = 4'd0;
				1: w = CFG_WIN_W'($urandom_range(MAX_WINDOW + 1, 15));
				2: w = 4'd1;
				3: w = CFG_WIN_W'(MAX_WINDOW);
				default: w = CFG_WIN_W'($urandom_range(2, MAX_WINDOW - 1));
			endcase
			cnt_sel = $urandom_range(0, 19);
			if (cnt_sel == 0) begin
				c = '0;
			end else if (cnt_sel < 14) begin
				c = CFG_BEAMS_W'($urandom_range(1, 12));
			end else if (cnt_sel < 19) begin
				c = CFG_BEAMS_W'($urandom_range(13, 40));
			end else begin
				c = CFG_BEAMS_W'($urandom_range(MAX_BEAMS + 1, 4095));
				w = CFG_WIN_W'($urandom_range(0, 1));
			end
			configure(w, c);
			cnt_eff = beam_average_scoreboard::eff_count(c);
			nscans = 160 / cnt_eff;
			if (nscans > 12)
				nscans = 12;
			if (nscans == 0)
				nscans = 1;
			if (beam_average_scoreboard::eff_window(w) == 1 && $urandom_range(0, 2) == 0)
				beats = $urandom_range(1, 3 * cnt_eff);
			else
				beats = nscans * cnt_eff;
			if (beats > 160)
				beats = $urandom_range(40, 160);
			steady = ($urandom_range(0, 3) == 0);
			if (!stall_done && beats_sent - start_beats > 500) begin
				// The receiver holds off while the sender keeps offering beats.
				steady = 1'b1;
				hold_request = 1'b1;
				stall_done = 1'b1;
				if (beats < 8)
					beats = 8;
			end
			send_random_beats(beats);
			steady = 1'b0;
		end

		drain();
		repeat (12) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
